// ----- sv/gst_pkg.sv -----
package gst_pkg;

  localparam int NUM_SLOTS_DEF  = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed field widths of the ports
  localparam int CMD_W     = 2;
  localparam int PAYLOAD_W = 32;
  localparam int TSLOT_W   = 6;
  localparam int GEN_W     = 32;
  localparam int STATUS_W  = 2;

  localparam logic [GEN_W-1:0] GEN_MAX   = '1;
  localparam logic [GEN_W-1:0] GEN_FIRST = GEN_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 2'd0,
    CMD_FIND    = 2'd1,
    CMD_RETIRE  = 2'd2,
    CMD_RECLAIM = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

endpackage

// ----- sv/generational_slot_table.sv -----
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+-------------------------------------------
// in_       | input     | in_valid/in_ready  | cmd, payload, payload_present,
//           |           |                    | token_slot, token_generation
// out_      | output    | out_valid/out_ready| status, result_slot, result_generation,
//           |           |                    | result_payload
//
// Each transaction is accepted in S_IDLE and completed in S_EXEC: the accept cycle resolves
// the flag vectors (first free slot, liveness) and reads the generation/payload memory;
// S_EXEC checks the generation, writes the entry back and loads the result register.
// The single memory port with its registered read sets this split.
// Reset (rst_n, synchronous) clears the occupied/retired flags, the open-slot count
// and the handshake state; the memory is not cleared.
// A result held by out_ready low stalls the execute cycle; in_ready is low until it
// completes. A new transaction may be accepted while the last result waits.

module generational_slot_table
  import gst_pkg::*;
#(
  parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [PAYLOAD_W-1:0] in_payload,
  input  logic                 in_payload_present,
  input  logic [TSLOT_W-1:0]   in_token_slot,
  input  logic [GEN_W-1:0]     in_token_generation,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  out_status,
  output logic [TSLOT_W-1:0]   out_result_slot,
  output logic [GEN_W-1:0]     out_result_generation,
  output logic [PAYLOAD_W-1:0] out_result_payload
);

  localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int CMP_W  = (CNT_W > TSLOT_W) ? CNT_W : TSLOT_W;
  localparam int WORD_W = GEN_W + DATA_WIDTH;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // control state
  state_t                state_r, state_nxt;
  logic [NUM_SLOTS-1:0]  occ_r, occ_nxt;
  logic [NUM_SLOTS-1:0]  ret_r, ret_nxt;
  logic [CNT_W-1:0]      in_use_r, in_use_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // captured transaction
  cmd_t                  cmd_r, cmd_nxt;
  logic [DATA_WIDTH-1:0] pay_r, pay_nxt;
  logic                  present_r, present_nxt;
  logic [GEN_W-1:0]      tgen_r, tgen_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  found_r, found_nxt;
  logic                  live_r, live_nxt;

  // result register
  status_t               status_r, status_nxt;
  logic [TSLOT_W-1:0]    rslot_r, rslot_nxt;
  logic [GEN_W-1:0]      rgen_r, rgen_nxt;
  logic [PAYLOAD_W-1:0]  rpay_r, rpay_nxt;

  // entry memory: {generation, payload}
  logic [WORD_W-1:0]     mem [NUM_SLOTS];
  logic [WORD_W-1:0]     rd_data_r;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [WORD_W-1:0]     wr_data;

  logic                  accept;
  logic                  issue;
  logic [NUM_SLOTS-1:0]  free_vec;
  logic                  any_free;
  logic [IDX_W-1:0]      first_free;
  logic                  tslot_in_range;
  logic [IDX_W-1:0]      tslot_idx;
  logic [GEN_W-1:0]      mem_gen;
  logic [DATA_WIDTH-1:0] mem_pay;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign issue     = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  assign out_valid             = out_valid_r;
  assign out_status            = status_r;
  assign out_result_slot       = rslot_r;
  assign out_result_generation = rgen_r;
  assign out_result_payload    = rpay_r;

  assign mem_gen = rd_data_r[WORD_W-1 -: GEN_W];
  assign mem_pay = rd_data_r[DATA_WIDTH-1:0];

  // open slots that are neither occupied nor retired; lowest one wins
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      free_vec[i] = ~occ_r[i] & ~ret_r[i] & (CNT_W'(i) < in_use_r);
    end
    any_free   = |free_vec;
    first_free = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        first_free = IDX_W'(i);
      end
    end
  end

  assign tslot_in_range = CMP_W'(in_token_slot) < CMP_W'(in_use_r);
  assign tslot_idx      = IDX_W'(in_token_slot);

  // memory read is issued in the accept cycle
  assign rd_en   = accept;
  assign rd_addr = (cmd_t'(in_cmd) == CMD_INSERT) ? first_free : tslot_idx;

  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    ret_nxt       = ret_r;
    in_use_nxt    = in_use_r;
    out_valid_nxt = out_valid_r && !out_ready;

    cmd_nxt     = cmd_r;
    pay_nxt     = pay_r;
    present_nxt = present_r;
    tgen_nxt    = tgen_r;
    idx_nxt     = idx_r;
    found_nxt   = found_r;
    live_nxt    = live_r;

    status_nxt = status_r;
    rslot_nxt  = rslot_r;
    rgen_nxt   = rgen_r;
    rpay_nxt   = rpay_r;

    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = {mem_gen, pay_r};

    if (accept) begin
      state_nxt   = S_EXEC;
      cmd_nxt     = cmd_t'(in_cmd);
      pay_nxt     = DATA_WIDTH'(in_payload);
      present_nxt = in_payload_present;
      tgen_nxt    = in_token_generation;
      found_nxt   = any_free;
      if (cmd_t'(in_cmd) == CMD_INSERT) begin
        idx_nxt = any_free ? first_free : IDX_W'(in_use_r);
      end else begin
        idx_nxt = tslot_idx;
      end
      // flags of the token's slot; the generation is checked in S_EXEC
      live_nxt = tslot_in_range && occ_r[tslot_idx] && !ret_r[tslot_idx];
    end

    if (issue) begin
      state_nxt     = S_IDLE;
      out_valid_nxt = 1'b1;
      status_nxt    = ST_NOT_FOUND;
      rslot_nxt     = '0;
      rgen_nxt      = '0;
      rpay_nxt      = '0;
      case (cmd_r)
        CMD_INSERT: begin
          if (!present_r) begin
            status_nxt = ST_INVALID;
          end else if (found_r) begin
            if (mem_gen == GEN_MAX) begin
              status_nxt = ST_EXHAUSTED;
            end else begin
              wr_en          = 1'b1;
              wr_data        = {mem_gen + GEN_W'(1), pay_r};
              occ_nxt[idx_r] = 1'b1;
              status_nxt     = ST_OK;
              rslot_nxt      = TSLOT_W'(idx_r);
              rgen_nxt       = mem_gen + GEN_W'(1);
            end
          end else if (in_use_r == CNT_W'(NUM_SLOTS)) begin
            status_nxt = ST_EXHAUSTED;
          end else begin
            // open a new slot at the end
            wr_en          = 1'b1;
            wr_data        = {GEN_FIRST, pay_r};
            occ_nxt[idx_r] = 1'b1;
            ret_nxt[idx_r] = 1'b0;
            in_use_nxt     = in_use_r + CNT_W'(1);
            status_nxt     = ST_OK;
            rslot_nxt      = TSLOT_W'(idx_r);
            rgen_nxt       = GEN_FIRST;
          end
        end
        CMD_FIND: begin
          if (live_r && (mem_gen == tgen_r)) begin
            status_nxt = ST_OK;
            rpay_nxt   = PAYLOAD_W'(mem_pay);
          end
        end
        CMD_RETIRE: begin
          if (live_r && (mem_gen == tgen_r)) begin
            ret_nxt[idx_r] = 1'b1;
            status_nxt     = ST_OK;
          end
        end
        CMD_RECLAIM: begin
          occ_nxt    = occ_r & ~ret_r;
          ret_nxt    = '0;
          status_nxt = ST_OK;
        end
        default: begin
          status_nxt = ST_NOT_FOUND;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    pay_r     <= pay_nxt;
    present_r <= present_nxt;
    tgen_r    <= tgen_nxt;
    idx_r     <= idx_nxt;
    found_r   <= found_nxt;
    live_r    <= live_nxt;
    status_r  <= status_nxt;
    rslot_r   <= rslot_nxt;
    rgen_r    <= rgen_nxt;
    rpay_r    <= rpay_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      ret_r       <= '0;
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      ret_r       <= ret_nxt;
      in_use_r    <= in_use_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // single-port style entry memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import gst_pkg::*;

  // Stimulus volume and run limits.
  localparam int RANDOM_ITEMS = 1330;
  localparam int PHASE_ITEMS  = 450;   // transactions per idling phase
  localparam int MIX_ITEMS    = 150;   // random transactions per command mix
  localparam int STALL_LIMIT  = 2000;  // cycles with no handshake on either channel
  localparam int DRAIN_CYCLES = 8;     // margin after the last checked response
  localparam int MAX_REPORTS  = 40;

  typedef struct packed {
    cmd_t             cmd;
    logic [PAYLOAD_W-1:0] payload;
    logic             present;
    logic [TSLOT_W-1:0] tslot;
    logic [GEN_W-1:0] tgen;
  } table_cmd_t;

  typedef struct packed {
    status_t              status;
    logic [TSLOT_W-1:0]   slot;
    logic [GEN_W-1:0]     gen;
    logic [PAYLOAD_W-1:0] data;
  } table_resp_t;

  // Random command mixes: filling drives the table to full, the others
  // exercise lookup, retire and reclaim against a populated table.
  typedef enum int {MIX_FILL, MIX_CHURN, MIX_RETIRE} cmd_mix_t;

  logic                 clk   = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid            = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     in_cmd              = '0;
  logic [PAYLOAD_W-1:0] in_payload          = '0;
  logic                 in_payload_present  = 1'b0;
  logic [TSLOT_W-1:0]   in_token_slot       = '0;
  logic [GEN_W-1:0]     in_token_generation = '0;
  logic                 out_valid;
  logic                 out_ready           = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic [TSLOT_W-1:0]   out_result_slot;
  logic [GEN_W-1:0]     out_result_generation;
  logic [PAYLOAD_W-1:0] out_result_payload;

  generational_slot_table dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_cmd               (in_cmd),
    .in_payload           (in_payload),
    .in_payload_present   (in_payload_present),
    .in_token_slot        (in_token_slot),
    .in_token_generation  (in_token_generation),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_result_slot      (out_result_slot),
    .out_result_generation(out_result_generation),
    .out_result_payload   (out_result_payload)
  );

  always #4 clk = ~clk;

  // Shadow of the slot table, advanced once per accepted transaction.
  int                   tbl_open;          // slots opened so far
  bit                   tbl_busy    [NUM_SLOTS_DEF];
  bit                   tbl_retired [NUM_SLOTS_DEF];
  bit [GEN_W-1:0]       tbl_gen     [NUM_SLOTS_DEF];
  bit [PAYLOAD_W-1:0]   tbl_data    [NUM_SLOTS_DEF];

  table_cmd_t  cmd_backlog[$];    // commands not yet offered to the block
  table_resp_t due_responses[$];  // predicted responses, oldest first
  table_cmd_t  cur_cmd;
  int          n_posted   = 0;
  int          n_accepted = 0;
  int          n_checked  = 0;
  int          n_errors   = 0;
  int          stall_cycles = 0;

  // Applies one command to the shadow table and returns the response it yields.
  function automatic table_resp_t table_apply(table_cmd_t c);
    table_resp_t r;
    int          free_idx;
    int          i;
    bit          live;
    r.status = ST_NOT_FOUND;
    r.slot   = '0;
    r.gen    = '0;
    r.data   = '0;
    // token is live only on an open, occupied, unretired slot of matching generation
    live = (int'(c.tslot) < tbl_open) && tbl_busy[c.tslot] && !tbl_retired[c.tslot] &&
           (tbl_gen[c.tslot] == c.tgen);
    case (c.cmd)
      CMD_INSERT: begin
        if (!c.present) begin
          r.status = ST_INVALID;
        end else begin
          free_idx = -1;
          for (i = 0; i < tbl_open; i++) begin
            if (free_idx < 0 && !tbl_busy[i] && !tbl_retired[i]) free_idx = i;
          end
          if (free_idx >= 0) begin
            // first free slot only; a saturated generation does not skip ahead
            if (tbl_gen[free_idx] == GEN_MAX) begin
              r.status = ST_EXHAUSTED;
            end else begin
              tbl_gen[free_idx]  = tbl_gen[free_idx] + 1'b1;
              tbl_data[free_idx] = c.payload;
              tbl_busy[free_idx] = 1'b1;
              r.status = ST_OK;
              r.slot   = TSLOT_W'(free_idx);
              r.gen    = tbl_gen[free_idx];
            end
          end else if (tbl_open >= NUM_SLOTS_DEF) begin
            r.status = ST_EXHAUSTED;
          end else begin
            tbl_gen[tbl_open]     = GEN_FIRST;
            tbl_data[tbl_open]    = c.payload;
            tbl_busy[tbl_open]    = 1'b1;
            tbl_retired[tbl_open] = 1'b0;
            r.status = ST_OK;
            r.slot   = TSLOT_W'(tbl_open);
            r.gen    = GEN_FIRST;
            tbl_open++;
          end
        end
      end
      CMD_FIND: begin
        if (live) begin
          r.status = ST_OK;
          r.data   = tbl_data[c.tslot];
        end
      end
      CMD_RETIRE: begin
        if (live) begin
          tbl_retired[c.tslot] = 1'b1;
          r.status = ST_OK;
        end
      end
      default: begin
        for (i = 0; i < NUM_SLOTS_DEF; i++) begin
          if (tbl_retired[i]) begin
            tbl_retired[i] = 1'b0;
            tbl_busy[i]    = 1'b0;
          end
        end
        r.status = ST_OK;
      end
    endcase
    return r;
  endfunction

  // Random command; most tokens come from the shadow table so find and retire
  // hit live, stale and retired slots, the rest are arbitrary.
  function automatic table_cmd_t make_random_cmd(cmd_mix_t mix);
    table_cmd_t c;
    int         roll;
    int         ins_w;
    int         find_w;
    int         ret_w;
    case (mix)
      MIX_FILL: begin
        ins_w = 75; find_w = 12; ret_w = 8;
      end
      MIX_CHURN: begin
        ins_w = 30; find_w = 35; ret_w = 25;
      end
      default: begin
        ins_w = 15; find_w = 25; ret_w = 50;
      end
    endcase
    roll = $urandom_range(99);
    if (roll < ins_w) c.cmd = CMD_INSERT;
    else if (roll < ins_w + find_w) c.cmd = CMD_FIND;
    else if (roll < ins_w + find_w + ret_w) c.cmd = CMD_RETIRE;
    else c.cmd = CMD_RECLAIM;
    c.payload = $urandom;
    c.present = ($urandom_range(99) >= 5);
    roll = $urandom_range(99);
    if (tbl_open > 0 && roll < 85) begin
      c.tslot = TSLOT_W'($urandom_range(tbl_open - 1));
      c.tgen  = tbl_gen[c.tslot];
      if (roll >= 75) c.tgen = roll[0] ? c.tgen - 1'b1 : GEN_W'($urandom);
    end else begin
      c.tslot = TSLOT_W'($urandom_range(NUM_SLOTS_DEF - 1));
      c.tgen  = $urandom;
    end
    return c;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (n_errors < MAX_REPORTS) begin
      $display("mismatch at %0t, response %0d: %s got %h expected %h",
               $realtime, n_checked, what, got, want);
    end
    n_errors++;
  endtask

  // Backlog is kept short and refilled at the falling edge, so random tokens
  // see a table state at most a few transactions old.
  task automatic post_cmd(table_cmd_t c);
    while (cmd_backlog.size() >= 2) @(negedge clk);
    cmd_backlog.insert(cmd_backlog.size(), c);
    n_posted++;
  endtask

  // Driver: offers the next command when the channel is free; the sender
  // idles 20% then 51% then never, stepping through phases by accepted count.
  always @(posedge clk) begin : drive
    int gap_pct;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      case (n_accepted / PHASE_ITEMS)
        0:       gap_pct = 20;
        1:       gap_pct = 51;
        default: gap_pct = 0;
      endcase
      if (in_valid && in_ready) begin
        due_responses.insert(due_responses.size(), table_apply(cur_cmd));
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (cmd_backlog.size() > 0 && $urandom_range(99) >= gap_pct) begin
          cur_cmd = cmd_backlog.pop_front();
          in_valid            <= 1'b1;
          in_cmd              <= cur_cmd.cmd;
          in_payload          <= cur_cmd.payload;
          in_payload_present  <= cur_cmd.present;
          in_token_slot       <= cur_cmd.tslot;
          in_token_generation <= cur_cmd.tgen;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each response transaction against the oldest prediction;
  // the receiver stalls 51% then 20% then never.
  always @(posedge clk) begin : watch
    int          stall_pct;
    table_resp_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      case (n_checked / PHASE_ITEMS)
        0:       stall_pct = 51;
        1:       stall_pct = 20;
        default: stall_pct = 0;
      endcase
      if (out_valid && out_ready) begin
        if (due_responses.size() == 0) begin
          report_mismatch("unexpected response, status", 32'(out_status), '0);
        end else begin
          want = due_responses.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", 32'(out_status), 32'(want.status));
          if (out_result_slot !== want.slot)
            report_mismatch("result_slot", 32'(out_result_slot), 32'(want.slot));
          if (out_result_generation !== want.gen)
            report_mismatch("result_generation", out_result_generation, want.gen);
          if (out_result_payload !== want.data)
            report_mismatch("result_payload", out_result_payload, want.data);
        end
        n_checked++;
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: any long stretch without a handshake on either side is a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int k;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, null payload, payload extremes, stale and wrong
    // generations, double retire, retired slot held until reclaim, reuse of a
    // freed slot with a bumped generation, never-opened slot.
    post_cmd('{CMD_RECLAIM, 32'h0,        1'b1, 6'd0,  32'd0});
    post_cmd('{CMD_FIND,    32'h0,        1'b0, 6'd0,  32'd0});
    post_cmd('{CMD_INSERT,  32'h1234_5678, 1'b0, 6'd0, 32'd0});
    post_cmd('{CMD_INSERT,  32'h0,        1'b1, 6'd0,  32'd0});
    post_cmd('{CMD_INSERT,  32'hFFFF_FFFF, 1'b1, 6'd0, 32'd0});
    post_cmd('{CMD_INSERT,  32'hA5A5_A5A5, 1'b1, 6'd0, 32'd0});
    post_cmd('{CMD_FIND,    32'h0,        1'b1, 6'd0,  32'd1});
    post_cmd('{CMD_FIND,    32'h0,        1'b1, 6'd1,  32'd1});
    post_cmd('{CMD_FIND,    32'h0,        1'b1, 6'd1,  32'hFFFF_FFFF});
    post_cmd('{CMD_FIND,    32'h0,        1'b1, 6'd63, 32'd1});
    post_cmd('{CMD_RETIRE,  32'h0,        1'b1, 6'd1,  32'd1});
    post_cmd('{CMD_RETIRE,  32'h0,        1'b1, 6'd1,  32'd1});
    post_cmd('{CMD_FIND,    32'h0,        1'b1, 6'd1,  32'd1});
    post_cmd('{CMD_INSERT,  32'h5A5A_5A5A, 1'b1, 6'd0, 32'd0});
    post_cmd('{CMD_RECLAIM, 32'h0,        1'b1, 6'd0,  32'd0});
    post_cmd('{CMD_FIND,    32'h0,        1'b1, 6'd1,  32'd1});
    post_cmd('{CMD_INSERT,  32'h8000_0001, 1'b1, 6'd0, 32'd0});
    post_cmd('{CMD_FIND,    32'h0,        1'b1, 6'd1,  32'd2});
    post_cmd('{CMD_RETIRE,  32'h0,        1'b1, 6'd0,  32'd1});
    post_cmd('{CMD_RETIRE,  32'h0,        1'b1, 6'd2,  32'd1});
    post_cmd('{CMD_RECLAIM, 32'h0,        1'b1, 6'd0,  32'd0});
    post_cmd('{CMD_INSERT,  32'h0000_0001, 1'b1, 6'd0, 32'd0});
    post_cmd('{CMD_INSERT,  32'h7FFF_FFFF, 1'b1, 6'd0, 32'd0});
    post_cmd('{CMD_FIND,    32'h0,        1'b1, 6'd2,  32'd2});

    // Random: the mix rotates so the table fills to capacity (exhausted
    // inserts) and is then churned and drained repeatedly.
    // A saturated generation needs 2^32 - 2 reuses of one slot and is out of reach.
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      post_cmd(make_random_cmd(cmd_mix_t'((k / MIX_ITEMS) % 3)));
    end

    // every posted command must come back as one response
    while (n_checked < n_posted) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0 && due_responses.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
